// File: hw/rtl/bsr_pkg.sv
// ============================================================================
// bsr_pkg
// Shared widths, defaults and controller/datapath interface types for the
// byte stream reassembler.
// ============================================================================
package bsr_pkg;

    // Field widths
    localparam int IDX_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;

    // Default reorder window depth in bytes
    localparam int WINDOW_BYTES_DEF = 64;

    // Packed stream widths
    localparam int S_TDATA_W = 80;   // index, value, free space, one pad bit
    localparam int M_TDATA_W = 16;   // byte, closed, pending count

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take the input item: end update and window store
        logic scan_step;   // current scan slot extends the run
        logic scan_done;   // commit the run: advance delivery point and count
        logic check;       // evaluate the close condition
        logic emit;        // load the next result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_hit;    // slot under scan is valid and room remains
        logic out_free;    // output register can take a result this cycle
        logic emit_last;   // the next result is the final one of this item
    } t_stat;

endpackage

// File: hw/rtl/bsr_ctrl.sv
// ============================================================================
// bsr_ctrl
// Controller for the byte stream reassembler: sequences item intake, the
// run scan over the valid bits, the close check and result delivery.
// ============================================================================
module bsr_ctrl
    import bsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    o_cmd.scan_done = 1'b1;
                    n_state         = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Only one command is ever issued per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("bsr_ctrl: more than one command in a cycle");

    // A scan always finishes through the close check before delivery
    a_check_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_done |=> o_cmd.check)
        else $error("bsr_ctrl: close check skipped after scan");

    // An item is only taken while no delivery is in progress
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SCAN))
        else $error("bsr_ctrl: item load did not start a scan");

endmodule

// File: hw/rtl/bsr_datapath.sv
// ============================================================================
// bsr_datapath
// Datapath for the byte stream reassembler: stream pointers, window byte
// memory with per-slot valid bits, run scan counters and output register.
// ============================================================================
module bsr_datapath
    import bsr_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [IDX_W-1:0]  i_byte_index,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic              i_has_byte,
    input  logic              i_ends_stream,
    input  logic [CNT_W-1:0]  i_free_space,
    input  logic              i_m_tready,
    output logic              o_out_tvalid,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_last,
    output logic              o_out_closed,
    output logic [CNT_W-1:0]  o_out_pending
);

    localparam int SW  = $clog2(WINDOW_BYTES);
    localparam int SW1 = SW + 1;
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW_BYTES);
    localparam logic [SW1-1:0]   WIN_SUM  = SW1'(WINDOW_BYTES);
    localparam logic [SW-1:0]    SLOT_TOP = SW'(WINDOW_BYTES - 1);

    // Stream state
    logic [IDX_W-1:0]        r_next_exp;
    logic [IDX_W-1:0]        r_end_idx;
    logic                    r_end_known;
    logic                    r_closed;
    logic [CNT_W-1:0]        r_count;
    logic [SW-1:0]           r_head;
    logic [WINDOW_BYTES-1:0] r_valid;
    logic [BYTE_W-1:0]       r_mem [WINDOW_BYTES];

    // Per-item working registers
    logic [CNT_W-1:0]        r_fs;
    logic [CNT_W-1:0]        r_run;
    logic [SW-1:0]           r_scan_ptr;
    logic [SW-1:0]           r_rd_ptr;
    logic [CNT_W-1:0]        r_left;

    // Output register
    logic                    r_out_tvalid;
    logic                    r_out_isbyte;
    logic [BYTE_W-1:0]       r_rd_data;
    logic                    r_out_last;
    logic                    r_out_closed;
    logic [CNT_W-1:0]        r_out_pending;

    logic                    w_borrow;
    logic [IDX_W-1:0]        w_diff;
    logic [CNT_W-1:0]        w_cap;
    logic                    w_in_win;
    logic [SW1-1:0]          w_sum;
    logic [SW-1:0]           w_slot;
    logic                    w_store;
    logic                    w_rd_en;

    // Acceptance window: next_expected <= index < next_expected + cap
    assign {w_borrow, w_diff} = {1'b0, i_byte_index} - {1'b0, r_next_exp};
    assign w_cap    = (i_free_space < WIN_CNT) ? i_free_space : WIN_CNT;
    assign w_in_win = !w_borrow && (w_diff[IDX_W-1:CNT_W] == '0)
                      && (w_diff[CNT_W-1:0] < w_cap);

    // Slot of the incoming byte relative to the head slot
    always_comb begin
        w_sum = {1'b0, r_head} + {1'b0, w_diff[SW-1:0]};
        if (w_sum >= WIN_SUM) begin
            w_sum = w_sum - WIN_SUM;
        end
        w_slot = w_sum[SW-1:0];
    end

    assign w_store = i_cmd.load && !r_closed && i_has_byte && w_in_win
                     && !r_valid[w_slot];
    assign w_rd_en = i_cmd.emit && (r_left != '0);

    // Status to controller
    assign o_stat.scan_hit  = r_valid[r_scan_ptr] && (r_run < r_fs);
    assign o_stat.out_free  = !r_out_tvalid || i_m_tready;
    assign o_stat.emit_last = (r_left <= CNT_W'(1));

    // Window byte memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[w_slot] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Stream state: end index, delivery point, stored count, close flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_exp  <= '0;
            r_end_idx   <= '0;
            r_end_known <= 1'b0;
            r_closed    <= 1'b0;
            r_count     <= '0;
            r_head      <= '0;
        end else begin
            if (i_cmd.load && !r_closed && i_ends_stream) begin
                r_end_idx   <= i_byte_index + IDX_W'(i_has_byte);
                r_end_known <= 1'b1;
            end
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_done) begin
                r_next_exp <= r_next_exp + IDX_W'(r_run);
                r_count    <= r_count - r_run;
                r_head     <= r_scan_ptr;
            end
            if (i_cmd.check && r_end_known && (r_next_exp == r_end_idx)) begin
                r_closed <= 1'b1;
            end
        end
    end

    // Valid bits: set on store, cleared as each byte is read out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_store) begin
                r_valid[w_slot] <= 1'b1;
            end
            if (w_rd_en) begin
                r_valid[r_rd_ptr] <= 1'b0;
            end
        end
    end

    // Scan and delivery counters; a run never exceeds the window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fs       <= r_closed ? '0 : w_cap;
            r_run      <= '0;
            r_scan_ptr <= r_head;
        end
        if (i_cmd.scan_step) begin
            r_run      <= r_run + CNT_W'(1);
            r_scan_ptr <= (r_scan_ptr == SLOT_TOP) ? '0 : r_scan_ptr + SW'(1);
        end
        if (i_cmd.scan_done) begin
            r_rd_ptr <= r_head;
            r_left   <= r_run;
        end
        if (w_rd_en) begin
            r_rd_ptr <= (r_rd_ptr == SLOT_TOP) ? '0 : r_rd_ptr + SW'(1);
            r_left   <= r_left - CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_isbyte  <= (r_left != '0);
            r_out_last    <= (r_left <= CNT_W'(1));
            r_out_closed  <= r_closed;
            r_out_pending <= r_count;
        end
    end

    assign o_out_tvalid  = r_out_tvalid;
    assign o_out_valid   = r_out_isbyte;
    assign o_out_byte    = r_out_isbyte ? r_rd_data : '0;
    assign o_out_last    = r_out_last;
    assign o_out_closed  = r_out_closed;
    assign o_out_pending = r_out_pending;

    // Stored count never exceeds the window
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= WIN_CNT)
        else $error("bsr_datapath: stored count beyond window");

    // Every delivered byte comes from a valid slot
    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> r_valid[r_rd_ptr])
        else $error("bsr_datapath: read of an empty window slot");

    // A status-only result is always the last of its item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_tvalid && !r_out_isbyte) |-> r_out_last)
        else $error("bsr_datapath: status result not marked last");

    // Once closed the stream stays closed
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_closed)) |-> r_closed)
        else $error("bsr_datapath: closed stream reopened");

endmodule

// File: hw/rtl/byte_stream_reassembler_core.sv
// ============================================================================
// byte_stream_reassembler_core
// Rebuilds an in-order byte stream from indexed bytes that arrive out of
// order, holding early bytes in a reorder window until the gap fills.
// ============================================================================
//
//  Port group  Dir  tdata (low bit up)                      tuser      tlast
//  s (item)    in   byte_index, byte_value, free_space,pad  has_byte   ends_stream
//  m (result)  out  out_byte, stream_closed, pending_count  out_valid  last_of_run
//
//  An item runs from intake through the valid-bit scan and the close check to
//  its last result entering the output register: the scan walks one slot a
//  cycle, then the window memory's single read port yields one byte a cycle
//  while the output register is free (a status-only item yields one result).
//  Reset is synchronous and active low; all valid bits clear at once, no
//  clearing pass. A stalled result holds in the output register; the next
//  item is taken once the final result of the current one is registered.
//
module byte_stream_reassembler_core
    import bsr_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // byte_index[63:0], byte_value[71:64],
                                              // free_space[78:72], pad[79]
    input  logic                 i_s_tuser,   // has_byte
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // out_byte[7:0], stream_closed[8],
                                              // pending_count[15:9]
    output logic                 o_m_tuser,   // out_valid
    output logic                 o_m_tlast
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_out_closed;
    logic [CNT_W-1:0]  w_out_pending;

    // Sequencer
    bsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Window, pointers and output register
    bsr_datapath #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_byte_index  (i_s_tdata[IDX_W-1:0]),
        .i_byte_value  (i_s_tdata[IDX_W+BYTE_W-1:IDX_W]),
        .i_has_byte    (i_s_tuser),
        .i_ends_stream (i_s_tlast),
        .i_free_space  (i_s_tdata[IDX_W+BYTE_W+CNT_W-1:IDX_W+BYTE_W]),
        .i_m_tready    (i_m_tready),
        .o_out_tvalid  (o_m_tvalid),
        .o_out_valid   (o_m_tuser),
        .o_out_byte    (w_out_byte),
        .o_out_last    (o_m_tlast),
        .o_out_closed  (w_out_closed),
        .o_out_pending (w_out_pending)
    );

    // Result packing
    assign o_m_tdata = {w_out_pending, w_out_closed, w_out_byte};

endmodule

// File: tb/byte_stream_reassembler_core_test.sv
// ============================================================================
// byte_stream_reassembler_core_test
// Self-checking bench for the byte stream reassembler. A scoreboard class
// mirrors the reorder window, the delivery point and the end index, works
// out the results of every input transaction and compares each output
// transaction with the oldest one due. Stimulus is a directed opening over
// the corner cases, then shuffled blocks of consecutive bytes mixed with old,
// far, duplicate, empty and end-marker items, and finally a clean close.
// ============================================================================
module byte_stream_reassembler_core_test;
    import bsr_pkg::*;

    localparam int WIN         = WINDOW_BYTES_DEF;
    localparam int ITEM_BUDGET = 450;
    localparam int QUIET_AFTER = 370;     // no idling beyond this item count
    localparam int HOLD_AT     = 120;     // long receiver hold starts here
    localparam int PAUSE_AT    = 250;     // sender waits for a full drain here
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 160;     // covers the drain of one full-window item
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] value;
        logic              has_byte;
        logic              ends;
        logic [CNT_W-1:0]  free;
    } stream_item_t;

    typedef struct packed {
        logic              delivers;
        logic [BYTE_W-1:0] data;
        logic              is_last;
        logic              closed;
        logic [CNT_W-1:0]  pending;
    } reasm_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: window mirror plus queue of results still due
    // ------------------------------------------------------------------------
    class reassembly_scoreboard;
        logic [BYTE_W-1:0] slot_data [WIN];
        bit                slot_valid[WIN];
        logic [IDX_W-1:0]  next_idx;
        logic [IDX_W-1:0]  end_idx;
        bit                end_known;
        bit                closed;
        int unsigned       stored;
        reasm_result_t     due_q[$];
        int                errors;

        function void note_item(stream_item_t it);
            reasm_result_t run[$];
            reasm_result_t r;
            int unsigned   cap;
            int unsigned   sent;
            int unsigned   s;
            sent = 0;
            if (!closed) begin
                cap = (it.free < WIN) ? it.free : WIN;
                if (it.ends) begin
                    end_idx   = it.idx + IDX_W'(it.has_byte);
                    end_known = 1'b1;
                end
                // store when inside the accept range; duplicates keep the old value
                if (it.has_byte && it.idx >= next_idx && (it.idx - next_idx) < cap) begin
                    s = int'(it.idx % WIN);
                    if (!slot_valid[s]) begin
                        slot_valid[s] = 1'b1;
                        slot_data[s]  = it.value;
                        stored++;
                    end
                end
                // drain the contiguous run, bounded by downstream room
                while (sent < it.free && slot_valid[int'(next_idx % WIN)]) begin
                    s = int'(next_idx % WIN);
                    r = '0;
                    r.delivers = 1'b1;
                    r.data     = slot_data[s];
                    run.insert(run.size(), r);
                    slot_valid[s] = 1'b0;
                    stored--;
                    next_idx++;
                    sent++;
                end
                if (end_known && next_idx == end_idx)
                    closed = 1'b1;
            end
            if (run.size() == 0) begin
                r = '0;
                run.insert(0, r);
            end
            foreach (run[k]) begin
                r         = run[k];
                r.is_last = (k == run.size() - 1);
                r.closed  = closed;
                r.pending = CNT_W'(stored);
                due_q.insert(due_q.size(), r);
            end
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(reasm_result_t got);
            reasm_result_t want;
            if (due_q.size() == 0) begin
                $error("result with nothing due: out_valid %0d out_byte %0h",
                       got.delivers, got.data);
                errors++;
                return;
            end
            want = due_q.pop_front();
            compare_field("out_valid",     want.delivers, got.delivers);
            compare_field("out_byte",      want.data,     got.data);
            compare_field("last_of_run",   want.is_last,  got.is_last);
            compare_field("stream_closed", want.closed,   got.closed);
            compare_field("pending_count", want.pending,  got.pending);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 i_s_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;

    reassembly_scoreboard sb = new();
    int  n_sent;
    bit  quiet;
    bit  hold_req;
    int  rx_hold;
    int  cycles;

    byte_stream_reassembler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // byte_index, byte_value, free_space, pad
        .i_s_tuser  (i_s_tuser),   // has_byte
        .i_s_tlast  (i_s_tlast),   // ends_stream
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // out_byte, stream_closed, pending_count
        .o_m_tuser  (o_m_tuser),   // out_valid
        .o_m_tlast  (o_m_tlast)    // last_of_run
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("byte_stream_reassembler_core: mismatch");
            $finish;
        end
    end

    // Output monitor: every accepted result transaction goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result({o_m_tuser, o_m_tdata[7:0], o_m_tlast, o_m_tdata[8],
                             o_m_tdata[15:9]});
    end

    // Idling is off in every fourth stretch of 50 items and in the tail
    function automatic bit idling_on();
        return !quiet && ((n_sent / 50) % 4 != 3);
    endfunction

    // Receiver: random stall bursts and one long hold on request
    initial begin
        i_m_tready = 1'b0;
        rx_hold    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rx_hold  = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready = 1'b0;
            end else if (idling_on() && $urandom_range(0, 5) == 0) begin
                rx_hold    = $urandom_range(0, 13);
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    function automatic stream_item_t mk_item(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] value,
                                             bit has_byte, bit ends, int free);
        stream_item_t it;
        it.idx      = idx;
        it.value    = value;
        it.has_byte = has_byte;
        it.ends     = ends;
        it.free     = CNT_W'(free);
        return it;
    endfunction

    function automatic int pick_free();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return WIN;
        else if (k < 65)
            return 0;
        return $urandom_range(0, WIN);
    endfunction

    // Offer one item from a falling edge and wait for its transaction
    task automatic send_item(stream_item_t it);
        if (idling_on() && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_tdata  = {1'b0, it.free, it.value, it.idx};
        i_s_tuser  = it.has_byte;
        i_s_tlast  = it.ends;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;
        @(negedge i_clk);
        if (n_sent == PAUSE_AT) begin
            i_s_tvalid = 1'b0;
            while (sb.due_q.size() != 0)
                @(negedge i_clk);
        end
    endtask

    // One unrelated item: near, exact, old, far, wild, empty or end marker
    task automatic send_noise();
        logic [IDX_W-1:0] nx;
        int               k;
        nx = sb.next_idx;
        k  = $urandom_range(0, 99);
        if (k < 40)
            send_item(mk_item(nx + $urandom_range(0, 70), 8'($urandom), 1, 0, pick_free()));
        else if (k < 55)
            send_item(mk_item(nx, 8'($urandom), 1, 0, pick_free()));
        else if (k < 67)
            send_item(mk_item(nx - $urandom_range(1, (nx > 80) ? 80 : 1), 8'($urandom), 1, 0,
                              pick_free()));
        else if (k < 77)
            send_item(mk_item(nx + $urandom_range(64, 300), 8'($urandom), 1, 0, WIN));
        else if (k < 85)
            send_item(mk_item({$urandom, $urandom}, 8'($urandom), 1, 0, pick_free()));
        else if (k < 93)
            send_item(mk_item(nx + $urandom_range(0, 63), 8'($urandom), 0, 0, pick_free()));
        else if (nx > 90 && $urandom_range(0, 1) == 0)
            // end behind delivery: the stream can never close on it
            send_item(mk_item(nx - $urandom_range(2, 80), 8'($urandom),
                              1'($urandom_range(0, 1)), 1, pick_free()));
        else
            send_item(mk_item(nx + 4096 + $urandom_range(0, 4096), 8'($urandom),
                              1'($urandom_range(0, 1)), 1, pick_free()));
    endtask

    // Consecutive bytes from the delivery point in shuffled order
    task automatic send_shuffled_block();
        logic [IDX_W-1:0] base;
        int               order[$];
        int               len;
        int               j;
        int               tmp;
        base = sb.next_idx;
        len  = ($urandom_range(0, 2) == 0) ? $urandom_range(40, WIN) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
            order.insert(order.size(), i);
        for (int i = len - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            send_item(mk_item(base + order[i], 8'($urandom), 1, 0,
                              ($urandom_range(0, 4) == 0) ? pick_free() : WIN));
        end
    endtask

    // Fill every gap below the highest stored byte and end right after it
    task automatic close_stream();
        logic [IDX_W-1:0] base;
        int               top;
        base = sb.next_idx;
        top  = -1;
        for (int k = 0; k < WIN; k++)
            if (sb.slot_valid[int'((base + k) % WIN)])
                top = k;
        send_item(mk_item(base + top + 1, 8'h00, 0, 1, WIN));
        for (int k = top; k >= 0; k--)
            if (!sb.slot_valid[int'((base + k) % WIN)])
                send_item(mk_item(base + k, 8'($urandom), 1, 0, WIN));
    endtask

    // Main sequence
    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_s_tlast  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed opening: zero room, in-order, early, duplicate, room-limited drain
        send_item(mk_item(64'd0, 8'h11, 1, 0, 0));
        send_item(mk_item(64'd0, 8'hA5, 1, 0, WIN));
        send_item(mk_item(64'd3, 8'h33, 1, 0, WIN));
        send_item(mk_item(64'd3, 8'hCC, 1, 0, WIN));
        send_item(mk_item(64'd2, 8'h22, 1, 0, WIN));
        send_item(mk_item(64'd1, 8'h00, 1, 0, 1));
        send_item(mk_item(64'd0, 8'h00, 0, 0, WIN));
        // old byte, far bytes at full and reduced room, one just inside
        send_item(mk_item(64'd1, 8'h5A, 1, 0, WIN));
        send_item(mk_item(sb.next_idx + WIN, 8'h77, 1, 0, WIN));
        send_item(mk_item(sb.next_idx + 5, 8'h99, 1, 0, 5));
        send_item(mk_item(sb.next_idx + 4, 8'h44, 1, 0, 5));
        // top index dropped; as an end it wraps to zero, behind delivery
        send_item(mk_item('1, 8'hFF, 1, 0, WIN));
        send_item(mk_item('1, 8'h7E, 1, 1, WIN));
        send_item(mk_item(sb.next_idx + 9000, 8'h00, 0, 1, WIN));
        send_item(mk_item(sb.next_idx + 9001, 8'h3C, 1, 1, 63));
        send_item(mk_item(sb.next_idx + WIN - 1, 8'h80, 1, 0, WIN));
        send_item(mk_item(sb.next_idx + WIN - 1, 8'h80, 1, 0, WIN - 1));
        send_item(mk_item(sb.next_idx, 8'hFF, 1, 0, WIN));
        send_item(mk_item({$urandom, $urandom}, 8'($urandom), 1, 0, WIN));

        // Random part, mostly well-formed blocks
        while (n_sent < ITEM_BUDGET) begin
            if (n_sent >= QUIET_AFTER)
                quiet = 1'b1;
            if ($urandom_range(0, 9) < 6)
                send_shuffled_block();
            else
                send_noise();
        end
        quiet = 1'b1;

        // Close the stream, then items after the close
        close_stream();
        send_item(mk_item(sb.next_idx, 8'hE1, 1, 0, WIN));
        send_item(mk_item(sb.next_idx + 1, 8'h00, 0, 1, WIN));
        i_s_tvalid = 1'b0;

        while (sb.due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("byte_stream_reassembler_core: match");
        else
            $display("byte_stream_reassembler_core: mismatch");
        $finish;
    end

endmodule
